// ----- sv/plc_pkg.sv -----
// ----------------------------------------------------------------------------
// plc_pkg
// shared types, codes and helpers for the positional list store
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int IDX_W        = 4;
    localparam int CNT_OUT_W    = 5;
    localparam int CHUNK_W      = 16;
    localparam int DEF_CAPACITY = 16;

    typedef enum logic [2:0] {
        REQ_READ   = 3'd0,
        REQ_WRITE  = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_SEARCH = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [POS_W-1:0]  pos;
    } t_cell_cmd;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              hit;
        logic [IDX_W-1:0]  idx;
    } t_scan_res;

    // lowest set bit of a chunk of match flags
    function automatic logic [IDX_W-1:0] first_set(input logic [CHUNK_W-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/plc_cell.sv -----
// ----------------------------------------------------------------------------
// plc_cell
// one list entry: holds a word, shifts with its neighbours, compares the key
// ----------------------------------------------------------------------------
`default_nettype none

module plc_cell
    import plc_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic              i_clk,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic [DATA_W-1:0] i_val,
    input  wire logic [DATA_W-1:0] i_prev,
    input  wire logic [DATA_W-1:0] i_next,
    input  wire logic [CW-1:0]     i_count,
    output logic [DATA_W-1:0]      o_val,
    output logic                   o_match
);

    logic [DATA_W-1:0] r_val;
    logic              w_at;
    logic              w_above;

    assign w_at    = (IDX == int'(i_cmd.pos));
    assign w_above = (IDX > int'(i_cmd.pos));

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_WRITE: begin
                if (w_at) r_val <= i_val;
            end
            CELL_INSERT: begin
                if (w_at) r_val <= i_val;
                else if (w_above) r_val <= i_prev;
            end
            CELL_DELETE: begin
                if (w_at || w_above) r_val <= i_next;
            end
            default: begin
            end
        endcase
    end

    assign o_val   = r_val;
    assign o_match = (CW'(IDX) < i_count) && (r_val == i_val);

endmodule

`default_nettype wire

// ----- sv/plc_scan.sv -----
// ----------------------------------------------------------------------------
// plc_scan
// first-match search over the registered match flags, one chunk a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module plc_scan
    import plc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [CAPACITY-1:0] i_match,
    output t_scan_res                o_res
);

    localparam int NCH = (CAPACITY + CHUNK_W - 1) / CHUNK_W;
    localparam int VW  = NCH * CHUNK_W;
    localparam int CKW = (NCH > 1) ? $clog2(NCH) : 1;

    logic [VW-1:0]      r_vec;
    logic [CKW-1:0]     r_chunk;
    logic               r_busy;
    logic [CHUNK_W-1:0] w_low;
    logic               w_hit;
    logic               w_last;

    assign w_low  = r_vec[CHUNK_W-1:0];
    assign w_hit  = (w_low != '0);
    assign w_last = (r_chunk == CKW'(NCH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_chunk <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_chunk <= '0;
        end else if (r_busy) begin
            if (w_hit || w_last) r_busy <= 1'b0;
            else r_chunk <= r_chunk + CKW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) r_vec <= VW'(i_match);
        else if (r_busy) r_vec <= r_vec >> CHUNK_W;
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_busy && (w_hit || w_last);
    assign o_res.hit  = w_hit;
    assign o_res.idx  = w_hit ? first_set(w_low) : '0;

endmodule

`default_nettype wire

// ----- sv/positional_list_store_core.sv -----
// ----------------------------------------------------------------------------
// positional_list_store_core
// ordered list of signed words with read, write, insert, delete and search
// ----------------------------------------------------------------------------
//  port group  dir  tdata (low bit up)                      tuser
//  s_*         in   position[4:0], data_value[36:5]         req_type[2:0]
//  m_*         out  read_value[31:0], found_index[35:32],   status[1:0]
//                   entry_count[40:36]
//
//  read/write/insert/delete: result next cycle; one word per cycle unless stalled
//  search scans the match flags in 16-flag chunks, lowest index first
//  reset clears the entry count and the scan; entry words are not cleared
//  input stalls only while a search scans or the result register is full
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store_core
    import plc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // position, data_value, zero pad
    input  wire logic [2:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // read_value, found_index, entry_count, pad
    output logic [1:0]       m_tuser    // status
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = (CW > POS_W) ? CW : POS_W;
    localparam int RD_N = (CAPACITY < 32) ? CAPACITY : 32;

    logic [CW-1:0]     r_count;
    logic              r_mvalid;
    logic [DATA_W-1:0] r_rd;
    logic [IDX_W-1:0]  r_idx;
    logic [CW-1:0]     r_ocount;
    t_status           r_st;

    logic [POS_W-1:0]  w_pos;
    logic [DATA_W-1:0] w_data;
    t_req              w_req;
    logic              w_acc;
    logic [PW-1:0]     w_pos_x;
    logic [PW-1:0]     w_cnt_x;
    logic              w_in_list;
    logic              w_full;
    t_status           w_st;
    t_cell_cmd         w_cmd;
    logic [DATA_W-1:0] w_rdval;
    logic [DATA_W-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    t_scan_res         w_scan;

    assign w_pos   = s_tdata[4:0];
    assign w_data  = s_tdata[36:5];
    assign w_req   = t_req'(s_tuser);
    assign w_acc   = s_tvalid && s_tready;
    assign w_pos_x = PW'(w_pos);
    assign w_cnt_x = PW'(r_count);
    assign w_in_list = (w_pos_x < w_cnt_x) && (int'(w_pos) < CAPACITY);
    assign w_full  = (int'(r_count) >= CAPACITY);

    assign s_tready = !w_scan.busy && (!r_mvalid || m_tready);

    always_comb begin
        w_st      = ST_OK;
        w_cmd.op  = CELL_HOLD;
        w_cmd.pos = w_pos;
        unique case (w_req)
            REQ_READ: begin
                if (!w_in_list) w_st = ST_RANGE;
            end
            REQ_WRITE: begin
                if (!w_in_list) w_st = ST_RANGE;
                else if (w_acc) w_cmd.op = CELL_WRITE;
            end
            REQ_INSERT: begin
                if (w_pos_x > w_cnt_x) w_st = ST_RANGE;
                else if (w_full) w_st = ST_FULL;
                else if (w_acc) w_cmd.op = CELL_INSERT;
            end
            REQ_DELETE: begin
                if (!w_in_list) w_st = ST_RANGE;
                else if (w_acc) w_cmd.op = CELL_DELETE;
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_val[g];
        end else begin : g_inner
            assign w_next = w_val[g+1];
        end
        plc_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_val   (w_data),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_count (r_count),
            .o_val   (w_val[g]),
            .o_match (w_match[g])
        );
    end

    always_comb begin
        w_rdval = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (w_pos == POS_W'(i)) w_rdval = w_rdval | w_val[i];
        end
    end

    plc_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc && (w_req == REQ_SEARCH)),
        .i_match (w_match),
        .o_res   (w_scan)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_mvalid <= w_scan.done || (w_acc && (w_req != REQ_SEARCH))
                        || (r_mvalid && !m_tready);
            if (w_acc && (w_req != REQ_SEARCH)) begin
                if (w_cmd.op == CELL_INSERT) r_count <= r_count + CW'(1);
                else if (w_cmd.op == CELL_DELETE) r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan.done) begin
            r_rd     <= '0;
            r_idx    <= w_scan.idx;
            r_ocount <= r_count;
            r_st     <= w_scan.hit ? ST_OK : ST_NOTFOUND;
        end else if (w_acc && (w_req != REQ_SEARCH)) begin
            r_rd  <= ((w_req == REQ_READ) && (w_st == ST_OK)) ? w_rdval : '0;
            r_idx <= '0;
            r_st  <= w_st;
            if (w_cmd.op == CELL_INSERT) r_ocount <= r_count + CW'(1);
            else if (w_cmd.op == CELL_DELETE) r_ocount <= r_count - CW'(1);
            else r_ocount <= r_count;
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = {7'd0, CNT_OUT_W'(r_ocount), r_idx, r_rd};
    assign m_tuser  = r_st;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= CAPACITY)
        else $error("entry count above capacity");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_req != REQ_SEARCH)) |=> m_tvalid)
        else $error("missing result after single-cycle request");

    a_no_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_req == REQ_SEARCH)) |=> (!s_tready && !m_tvalid))
        else $error("request taken or result shown during search");

endmodule

`default_nettype wire
